@@ design/pim_pkg.sv @@
// Shared constants, tables and types of the pair invariant mass pipeline.
package pim_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ANGLE_BITS_DEF    = 12;

   localparam int PT_W     = 16;
   localparam int ETA_W    = 14;
   localparam int PHI_W    = 12;
   localparam int FOURTH_W = 23;
   localparam int MASS_W   = 24;

   localparam int MAG_W     = 13;
   localparam int CS_W      = 34;
   localparam int EXP_STEPS = 13;
   localparam int P_W       = 32;
   localparam int RECIP_W   = 25;
   localparam int SH_W      = 31;
   localparam int MOM_W     = 24;
   localparam int PZ_W      = 30;
   localparam int E_W       = 31;
   localparam int SUM_W     = 60;
   localparam int M2_W      = 64;

   localparam logic signed [ETA_W-1:0] ETA_LIMIT = 14'sd5120;
   localparam logic signed [CS_W-1:0]  GAIN_Q30  = 34'sd652032874;

   localparam int T_PZ     = EXP_STEPS + RECIP_W + 3;
   localparam int T_SUM    = T_PZ + 3;
   localparam int T_ROOT   = T_SUM + SUM_W / 2;
   localparam int T_E      = T_ROOT + 1;
   localparam int LANE_LAT = T_E + 1;
   localparam int MERGE_LAT = 5 + M2_W / 2 + 1;
   localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT;

   typedef struct packed {
      logic signed [MOM_W-1:0] px;
      logic signed [MOM_W-1:0] py;
      logic signed [PZ_W-1:0]  pz;
      logic [E_W-1:0]          e;
   } four_vec_type;

   function automatic logic [31:0] atan_turn(input int i);
      logic [31:0] v;
      case (i)
         0:  v = 32'd536870912;
         1:  v = 32'd316933406;
         2:  v = 32'd167458907;
         3:  v = 32'd85004757;
         4:  v = 32'd42667331;
         5:  v = 32'd21354465;
         6:  v = 32'd10679838;
         7:  v = 32'd5340245;
         8:  v = 32'd2670163;
         9:  v = 32'd1335087;
         10: v = 32'd667544;
         11: v = 32'd333772;
         12: v = 32'd166886;
         13: v = 32'd83443;
         14: v = 32'd41722;
         15: v = 32'd20861;
         16: v = 32'd10430;
         17: v = 32'd5215;
         18: v = 32'd2608;
         19: v = 32'd1304;
         20: v = 32'd652;
         21: v = 32'd326;
         22: v = 32'd163;
         23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   function automatic logic [29:0] exp_q24(input int k);
      logic [29:0] v;
      case (k)
         0:  v = 30'd16793608;
         1:  v = 30'd16810016;
         2:  v = 30'd16842880;
         3:  v = 30'd16908801;
         4:  v = 30'd17041419;
         5:  v = 30'd17309781;
         6:  v = 30'd17859253;
         7:  v = 30'd19011076;
         8:  v = 30'd21542372;
         9:  v = 30'd27660953;
         10: v = 30'd45605201;
         11: v = 30'd123967790;
         12: v = 30'd916004956;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

@@ design/pim_delay.sv @@
// Fixed-length shift register that keeps side data aligned with the pipeline.
module pim_delay import pim_pkg::*; #(
   parameter int W = 1,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);
   logic [W-1:0] sr_ff [N];

   always_ff @(posedge clock) begin
      sr_ff[0] <= d;
      for (int i = 1; i < N; i++) begin
         sr_ff[i] <= sr_ff[i-1];
      end
   end

   assign q = sr_ff[N-1];
endmodule

@@ design/pim_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module pim_isqrt import pim_pkg::*; #(
   parameter int W = SUM_W
) (
   input  logic           clock,
   input  logic [W-1:0]   n,
   output logic [W/2-1:0] root
);
   localparam int K = W / 2;

   logic [W-1:0] rem_in [K];
   logic [W-1:0] res_in [K];
   logic [W-1:0] rem_ff [K];
   logic [W-1:0] res_ff [K];

   for (genvar k = 0; k < K; k++) begin : g_step
      localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
      logic [W-1:0] rem_prev;
      logic [W-1:0] res_prev;
      logic [W-1:0] trial;
      logic         ge;
      if (k == 0) begin : g_first
         assign rem_prev = n;
         assign res_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign res_prev = res_ff[k-1];
      end
      assign trial     = res_prev + BIT;
      assign ge        = rem_prev >= trial;
      assign rem_in[k] = ge ? rem_prev - trial : rem_prev;
      assign res_in[k] = ge ? (res_prev >> 1) + BIT : res_prev >> 1;
      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in[k];
         res_ff[k] <= res_in[k];
      end
   end

   assign root = res_ff[K-1][W/2-1:0];
endmodule

@@ design/pim_recip.sv @@
// Pipelined restoring divider that forms round(2^48 / p), one quotient bit per stage.
module pim_recip import pim_pkg::*; (
   input  logic               clock,
   input  logic [P_W-1:0]     p,
   output logic [RECIP_W-1:0] quo,
   output logic [P_W-1:0]     p_out
);
   logic [P_W-1:0]     rem_in [RECIP_W];
   logic [RECIP_W-1:0] q_in   [RECIP_W];
   logic [P_W-1:0]     rem_ff [RECIP_W];
   logic [RECIP_W-1:0] q_ff   [RECIP_W];
   logic [P_W-1:0]     p_ff   [RECIP_W];

   for (genvar j = 0; j < RECIP_W; j++) begin : g_step
      logic [P_W-1:0]     rem_prev;
      logic [RECIP_W-1:0] q_prev;
      logic [P_W-1:0]     p_prev;
      logic [P_W:0]       t;
      logic [P_W:0]       diff;
      logic               ge;
      if (j == 0) begin : g_first
         assign rem_prev = P_W'(1 << 23) + P_W'(p >> 26);
         assign q_prev   = '0;
         assign p_prev   = p;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign q_prev   = q_ff[j-1];
         assign p_prev   = p_ff[j-1];
      end
      // The numerator bits below 2^25 are the bits of p shifted down by one.
      assign t         = {rem_prev, p_prev[RECIP_W-j]};
      assign diff      = t - {1'b0, p_prev};
      assign ge        = t >= {1'b0, p_prev};
      assign rem_in[j] = ge ? diff[P_W-1:0] : t[P_W-1:0];
      assign q_in[j]   = {q_prev[RECIP_W-2:0], ge};
      always_ff @(posedge clock) begin
         rem_ff[j] <= rem_in[j];
         q_ff[j]   <= q_in[j];
         p_ff[j]   <= p_prev;
      end
   end

   assign quo   = q_ff[RECIP_W-1];
   assign p_out = p_ff[RECIP_W-1];
endmodule

@@ design/pim_cordic.sv @@
// Pipelined rotation CORDIC that gives cosine and sine in Q30.
module pim_cordic import pim_pkg::*; #(
   parameter int STAGES = CORDIC_STAGES_DEF
) (
   input  logic                   clock,
   input  logic signed [CS_W-1:0] z,
   input  logic                   flip,
   output logic signed [CS_W-1:0] cos_out,
   output logic signed [CS_W-1:0] sin_out
);
   logic signed [CS_W-1:0] x_in [STAGES];
   logic signed [CS_W-1:0] y_in [STAGES];
   logic signed [CS_W-1:0] z_in [STAGES];
   logic signed [CS_W-1:0] x_ff [STAGES];
   logic signed [CS_W-1:0] y_ff [STAGES];
   logic signed [CS_W-1:0] z_ff [STAGES];
   logic                   flip_ff [STAGES];
   logic signed [CS_W-1:0] cos_ff;
   logic signed [CS_W-1:0] sin_ff;

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic signed [CS_W-1:0] ATAN = $signed({2'b00, atan_turn(i)});
      logic signed [CS_W-1:0] xp;
      logic signed [CS_W-1:0] yp;
      logic signed [CS_W-1:0] zp;
      logic                   fp;
      if (i == 0) begin : g_first
         assign xp = GAIN_Q30;
         assign yp = '0;
         assign zp = z;
         assign fp = flip;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
         assign fp = flip_ff[i-1];
      end
      assign x_in[i] = (zp >= 0) ? xp - (yp >>> i) : xp + (yp >>> i);
      assign y_in[i] = (zp >= 0) ? yp + (xp >>> i) : yp - (xp >>> i);
      assign z_in[i] = (zp >= 0) ? zp - ATAN : zp + ATAN;
      always_ff @(posedge clock) begin
         x_ff[i]    <= x_in[i];
         y_ff[i]    <= y_in[i];
         z_ff[i]    <= z_in[i];
         flip_ff[i] <= fp;
      end
   end

   always_ff @(posedge clock) begin
      cos_ff <= flip_ff[STAGES-1] ? -x_ff[STAGES-1] : x_ff[STAGES-1];
      sin_ff <= flip_ff[STAGES-1] ? -y_ff[STAGES-1] : y_ff[STAGES-1];
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;
endmodule

@@ design/pim_lane.sv @@
// One particle lane: momentum components from pt, eta and phi, then the energy.
module pim_lane import pim_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
   parameter int ANGLE_BITS    = ANGLE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    mode,
   input  logic [PT_W-1:0]         pt,
   input  logic signed [ETA_W-1:0] eta,
   input  logic signed [PHI_W-1:0] phi,
   input  logic [FOURTH_W-1:0]     fourth,
   output four_vec_type            vec
);
   localparam logic signed [CS_W-1:0] QUARTER = 34'sd1073741824;
   localparam logic signed [CS_W-1:0] HALF    = 34'sd2147483648;
   localparam int D_PX = T_PZ - (CORDIC_STAGES + 3);

   logic signed [ETA_W-1:0] eta_sat;
   logic signed [ETA_W-1:0] eta_abs;
   logic [31:0]             ang;
   logic signed [CS_W-1:0]  z_raw;
   logic signed [CS_W-1:0]  z_in;
   logic                    flip_in;

   logic [PT_W-1:0]        pt0_ff;
   logic [MAG_W-1:0]       mag0_ff;
   logic                   neg0_ff;
   logic signed [CS_W-1:0] z0_ff;
   logic                   flip0_ff;
   logic                   mode0_ff;
   logic [FOURTH_W-1:0]    fourth0_ff;

   always_comb begin
      eta_sat = eta;
      if (eta > ETA_LIMIT) begin
         eta_sat = ETA_LIMIT;
      end else if (eta < -ETA_LIMIT) begin
         eta_sat = -ETA_LIMIT;
      end
      eta_abs = eta_sat[ETA_W-1] ? -eta_sat : eta_sat;
   end

   assign ang   = {{(32-PHI_W){phi[PHI_W-1]}}, phi} << (32 - ANGLE_BITS);
   assign z_raw = $signed({{(CS_W-32){ang[31]}}, ang});

   // Angles beyond a quarter turn are turned by half a turn and the results negated.
   always_comb begin
      z_in    = z_raw;
      flip_in = 1'b0;
      if (z_raw > QUARTER) begin
         z_in    = z_raw - HALF;
         flip_in = 1'b1;
      end else if (z_raw < -QUARTER) begin
         z_in    = z_raw + HALF;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pt0_ff     <= pt;
      mag0_ff    <= eta_abs[MAG_W-1:0];
      neg0_ff    <= eta_sat[ETA_W-1];
      z0_ff      <= z_in;
      flip0_ff   <= flip_in;
      mode0_ff   <= mode;
      fourth0_ff <= fourth;
   end

   // Transverse components.
   logic signed [CS_W-1:0] cos_v;
   logic signed [CS_W-1:0] sin_v;
   logic [PT_W-1:0]        pt_c;
   logic signed [50:0]     prodx_ff;
   logic signed [50:0]     prody_ff;
   logic signed [50:0]     rx;
   logic signed [50:0]     ry;
   logic signed [MOM_W-1:0] px_ff;
   logic signed [MOM_W-1:0] py_ff;
   logic signed [MOM_W-1:0] px_a;
   logic signed [MOM_W-1:0] py_a;

   pim_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
      .clock   (clock),
      .z       (z0_ff),
      .flip    (flip0_ff),
      .cos_out (cos_v),
      .sin_out (sin_v)
   );

   pim_delay #(.W(PT_W), .N(CORDIC_STAGES + 1)) u_dly_pt_c (
      .clock (clock), .d (pt0_ff), .q (pt_c)
   );

   assign rx = prodx_ff + 51'sd33554432;
   assign ry = prody_ff + 51'sd33554432;

   always_ff @(posedge clock) begin
      prodx_ff <= $signed({1'b0, pt_c}) * cos_v;
      prody_ff <= $signed({1'b0, pt_c}) * sin_v;
      px_ff    <= rx[26 +: MOM_W];
      py_ff    <= ry[26 +: MOM_W];
   end

   pim_delay #(.W(2 * MOM_W), .N(D_PX)) u_dly_pxy (
      .clock (clock), .d ({px_ff, py_ff}), .q ({px_a, py_a})
   );

   // Longitudinal component through exp(|eta|) and its reciprocal.
   logic [P_W-1:0]   p_in   [EXP_STEPS];
   logic [P_W-1:0]   p_ff   [EXP_STEPS];
   logic [MAG_W-1:0] mag_ff [EXP_STEPS];

   for (genvar k = 0; k < EXP_STEPS; k++) begin : g_exp
      logic [P_W-1:0]    pp;
      logic [MAG_W-1:0]  mp;
      logic [P_W+29:0]   prod;
      logic [P_W+29:0]   rnd;
      if (k == 0) begin : g_first
         assign pp = P_W'(1 << 24);
         assign mp = mag0_ff;
      end else begin : g_next
         assign pp = p_ff[k-1];
         assign mp = mag_ff[k-1];
      end
      assign prod    = {30'd0, pp} * {{P_W{1'b0}}, exp_q24(k)};
      assign rnd     = prod + (P_W+30)'(1 << 23);
      assign p_in[k] = mp[k] ? rnd[24 +: P_W] : pp;
      always_ff @(posedge clock) begin
         p_ff[k]   <= p_in[k];
         mag_ff[k] <= mp;
      end
   end

   logic [RECIP_W-1:0] recip;
   logic [P_W-1:0]     p_d;
   logic [PT_W-1:0]    pt_z;
   logic               neg_z;
   logic [SH_W-1:0]    sh_ff;
   logic [46:0]        prodz_ff;
   logic [46:0]        rz;
   logic signed [PZ_W-1:0] pz_ff;
   logic [P_W-1:0]     sh_diff;

   pim_recip u_recip (
      .clock (clock), .p (p_ff[EXP_STEPS-1]), .quo (recip), .p_out (p_d)
   );

   pim_delay #(.W(PT_W), .N(T_PZ - 2)) u_dly_pt_z (
      .clock (clock), .d (pt0_ff), .q (pt_z)
   );

   pim_delay #(.W(1), .N(T_PZ - 1)) u_dly_neg (
      .clock (clock), .d (neg0_ff), .q (neg_z)
   );

   assign sh_diff = (p_d >= P_W'(recip)) ? (p_d - P_W'(recip)) >> 1 : '0;
   assign rz      = prodz_ff + 47'd524288;

   always_ff @(posedge clock) begin
      sh_ff    <= sh_diff[SH_W-1:0];
      prodz_ff <= 47'(pt_z) * 47'(sh_ff);
      pz_ff    <= neg_z ? -$signed({3'b000, rz[46:20]}) : $signed({3'b000, rz[46:20]});
   end

   // Energy.
   logic [FOURTH_W:0]      mf_q;
   logic [FOURTH_W:0]      mf_e;
   logic signed [2*MOM_W-1:0] pxsq_ff;
   logic signed [2*MOM_W-1:0] pysq_ff;
   logic signed [2*PZ_W-1:0]  pzsq_ff;
   logic [53:0]            msq_ff;
   logic [SUM_W-1:0]       a_ff;
   logic [SUM_W-1:0]       b_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [SUM_W/2-1:0]     root;
   logic [E_W-1:0]         e_ff;
   logic [2*MOM_W+PZ_W-1:0] pvec_e;

   pim_delay #(.W(FOURTH_W + 1), .N(T_PZ)) u_dly_mf_q (
      .clock (clock), .d ({mode0_ff, fourth0_ff}), .q (mf_q)
   );

   pim_delay #(.W(FOURTH_W + 1), .N(T_ROOT - T_PZ)) u_dly_mf_e (
      .clock (clock), .d (mf_q), .q (mf_e)
   );

   always_ff @(posedge clock) begin
      pxsq_ff <= px_a * px_a;
      pysq_ff <= py_a * py_a;
      pzsq_ff <= pz_ff * pz_ff;
      msq_ff  <= {27'd0, mf_q[FOURTH_W-1:0], 4'd0} * {27'd0, mf_q[FOURTH_W-1:0], 4'd0};
      a_ff    <= SUM_W'(pxsq_ff) + SUM_W'(pysq_ff);
      b_ff    <= SUM_W'(pzsq_ff) + SUM_W'(msq_ff);
      sum_ff  <= a_ff + b_ff;
      e_ff    <= mf_e[FOURTH_W] ? E_W'({mf_e[FOURTH_W-1:0], 4'd0}) : E_W'(root);
   end

   pim_isqrt #(.W(SUM_W)) u_isqrt (
      .clock (clock), .n (sum_ff), .root (root)
   );

   pim_delay #(.W(2 * MOM_W + PZ_W), .N(T_E - T_PZ)) u_dly_pvec (
      .clock (clock), .d ({px_a, py_a, pz_ff}), .q (pvec_e)
   );

   assign vec.px = pvec_e[2*MOM_W+PZ_W-1 -: MOM_W];
   assign vec.py = pvec_e[MOM_W+PZ_W-1 -: MOM_W];
   assign vec.pz = pvec_e[PZ_W-1:0];
   assign vec.e  = e_ff;
endmodule

@@ design/pim_merge.sv @@
// Merging stage: sums the two four-vectors and forms the signed, saturated mass.
module pim_merge import pim_pkg::*; (
   input  logic                     clock,
   input  four_vec_type             vec_a,
   input  four_vec_type             vec_b,
   output logic signed [MASS_W-1:0] mass
);
   logic [E_W:0]              ex_ff;
   logic signed [MOM_W:0]     pxs_ff;
   logic signed [MOM_W:0]     pys_ff;
   logic signed [PZ_W:0]      pzs_ff;
   logic [2*E_W+1:0]          exsq_ff;
   logic signed [2*MOM_W+1:0] pxsq_ff;
   logic signed [2*MOM_W+1:0] pysq_ff;
   logic signed [2*PZ_W+1:0]  pzsq_ff;
   logic signed [M2_W+1:0]    s1_ff;
   logic signed [M2_W+1:0]    s2_ff;
   logic signed [M2_W+1:0]    m2_ff;
   logic signed [M2_W+1:0]    m2_abs;
   logic [M2_W-1:0]           mag_ff;
   logic                      neg_ff;
   logic                      neg_r;
   logic [M2_W/2-1:0]         root;
   logic [M2_W/2:0]           rr;
   logic [M2_W/2-4:0]         r;
   logic [M2_W/2-4:0]         r_neg;
   logic signed [MASS_W-1:0]  mass_in;
   logic signed [MASS_W-1:0]  mass_ff;

   localparam logic [M2_W/2-4:0] POS_MAX = (M2_W/2-3)'(8388607);
   localparam logic [M2_W/2-4:0] NEG_MAX = (M2_W/2-3)'(8388608);

   assign m2_abs = m2_ff[M2_W+1] ? -m2_ff : m2_ff;

   always_ff @(posedge clock) begin
      ex_ff   <= (E_W+1)'(vec_a.e) + (E_W+1)'(vec_b.e);
      pxs_ff  <= (MOM_W+1)'($signed(vec_a.px)) + (MOM_W+1)'($signed(vec_b.px));
      pys_ff  <= (MOM_W+1)'($signed(vec_a.py)) + (MOM_W+1)'($signed(vec_b.py));
      pzs_ff  <= (PZ_W+1)'($signed(vec_a.pz)) + (PZ_W+1)'($signed(vec_b.pz));
      exsq_ff <= (2*E_W+2)'(ex_ff) * (2*E_W+2)'(ex_ff);
      pxsq_ff <= pxs_ff * pxs_ff;
      pysq_ff <= pys_ff * pys_ff;
      pzsq_ff <= pzs_ff * pzs_ff;
      s1_ff   <= $signed({2'b00, exsq_ff}) - (M2_W+2)'(pxsq_ff);
      s2_ff   <= (M2_W+2)'(pysq_ff) + (M2_W+2)'(pzsq_ff);
      m2_ff   <= s1_ff - s2_ff;
      neg_ff  <= m2_ff[M2_W+1];
      mag_ff  <= m2_abs[M2_W-1:0];
      mass_ff <= mass_in;
   end

   pim_isqrt #(.W(M2_W)) u_isqrt (
      .clock (clock), .n (mag_ff), .root (root)
   );

   pim_delay #(.W(1), .N(M2_W / 2)) u_dly_neg (
      .clock (clock), .d (neg_ff), .q (neg_r)
   );

   assign rr    = {1'b0, root} + (M2_W/2+1)'(8);
   assign r     = rr[M2_W/2:4];
   assign r_neg = -r;

   always_comb begin
      if (!neg_r) begin
         mass_in = (r > POS_MAX) ? 24'sh7FFFFF : $signed(r[MASS_W-1:0]);
      end else begin
         mass_in = (r > NEG_MAX) ? 24'sh800000 : $signed(r_neg[MASS_W-1:0]);
      end
   end

   assign mass = mass_ff;
endmodule

@@ design/pair_invariant_mass.sv @@
// Top level of the two-particle invariant mass pipeline.
// One candidate pair is taken on every clock and busy never rises; each word
// leaves on the rsp_ ports marked by rsp_valid for one cycle, and the receiver
// cannot stall it. The datapath is fully pipelined: the phi CORDIC runs
// in parallel with the exp(|eta|) product chain and the 25-stage reciprocal
// divider, followed by the 30-stage energy square root in each particle lane,
// then the shared merging stage with its 32-stage mass square root.
module pair_invariant_mass import pim_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
   parameter int ANGLE_BITS    = ANGLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_mode,
   input  logic                     req_pair_present,
   input  logic [PT_W-1:0]          req_first_pt,
   input  logic signed [ETA_W-1:0]  req_first_eta,
   input  logic signed [PHI_W-1:0]  req_first_phi,
   input  logic [FOURTH_W-1:0]      req_first_mass_or_energy,
   input  logic [PT_W-1:0]          req_second_pt,
   input  logic signed [ETA_W-1:0]  req_second_eta,
   input  logic signed [PHI_W-1:0]  req_second_phi,
   input  logic [FOURTH_W-1:0]      req_second_mass_or_energy,
   output logic                     rsp_valid,
   output logic                     rsp_pair_valid,
   output logic signed [MASS_W-1:0] rsp_invariant_mass
);
   four_vec_type            vec_a;
   four_vec_type            vec_b;
   logic signed [MASS_W-1:0] mass;
   logic                    accept;
   logic [TOTAL_LAT-1:0]    valid_ff;
   logic [TOTAL_LAT-1:0]    valid_in;
   logic [TOTAL_LAT-1:0]    pair_ff;
   logic [TOTAL_LAT-1:0]    pair_in;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign valid_in = {valid_ff[TOTAL_LAT-2:0], accept};
   assign pair_in  = {pair_ff[TOTAL_LAT-2:0], req_pair_present};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
   end

   pim_lane #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_lane_a (
      .clock  (clock),
      .mode   (req_mode),
      .pt     (req_first_pt),
      .eta    (req_first_eta),
      .phi    (req_first_phi),
      .fourth (req_first_mass_or_energy),
      .vec    (vec_a)
   );

   pim_lane #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_lane_b (
      .clock  (clock),
      .mode   (req_mode),
      .pt     (req_second_pt),
      .eta    (req_second_eta),
      .phi    (req_second_phi),
      .fourth (req_second_mass_or_energy),
      .vec    (vec_b)
   );

   pim_merge u_merge (
      .clock (clock),
      .vec_a (vec_a),
      .vec_b (vec_b),
      .mass  (mass)
   );

   assign rsp_valid          = valid_ff[TOTAL_LAT-1];
   assign rsp_pair_valid     = pair_ff[TOTAL_LAT-1];
   assign rsp_invariant_mass = pair_ff[TOTAL_LAT-1] ? mass : '0;
endmodule

@@ design/pim_checker.sv @@
// Port-level checker for the pair invariant mass block, bound to the top level.
module pim_port_checks import pim_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     req_pair_present,
   input logic                     rsp_valid,
   input logic                     rsp_pair_valid,
   input logic signed [MASS_W-1:0] rsp_invariant_mass
);
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##TOTAL_LAT rsp_valid)
      else $error("accepted word did not produce a result on time");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, TOTAL_LAT))
      else $error("result strobe without a matching accepted word");

   a_no_pair: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_pair_present) |-> ##TOTAL_LAT !rsp_pair_valid)
      else $error("mass flagged valid for a word without a pair");

   a_zero_mass: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_pair_valid) |-> (rsp_invariant_mass == '0))
      else $error("nonzero mass on a result without a pair");
endmodule

bind pair_invariant_mass pim_port_checks u_pim_port_checks (.*);

@@ test/pim_checker.sv @@
// Checker that predicts and compares every pair invariant mass word.
`timescale 1ns / 100ps
module pim_checker import pim_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic                     req_mode,
   input  logic                     req_pair_present,
   input  logic [PT_W-1:0]          req_first_pt,
   input  logic signed [ETA_W-1:0]  req_first_eta,
   input  logic signed [PHI_W-1:0]  req_first_phi,
   input  logic [FOURTH_W-1:0]      req_first_mass_or_energy,
   input  logic [PT_W-1:0]          req_second_pt,
   input  logic signed [ETA_W-1:0]  req_second_eta,
   input  logic signed [PHI_W-1:0]  req_second_phi,
   input  logic [FOURTH_W-1:0]      req_second_mass_or_energy,
   input  logic                     rsp_valid,
   input  logic                     rsp_pair_valid,
   input  logic signed [MASS_W-1:0] rsp_invariant_mass,
   output int                       errors,
   output int                       pending
);

   typedef struct {
      logic                     pair_valid;
      logic signed [MASS_W-1:0] mass;
   } mass_word_type;

   typedef struct {
      longint px;
      longint py;
      longint pz;
      longint e;
   } momentum_type;

   localparam longint ROT_GAIN = 64'sd652032874;
   localparam longint TURN_STEP [24] = '{
      536870912, 316933406, 167458907, 85004757, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
   localparam longint unsigned EXP_FACTOR [13] = '{
      16793608, 16810016, 16842880, 16908801, 17041419, 17309781, 17859253,
      19011076, 21542372, 27660953, 45605201, 123967790, 916004956};

   mass_word_type expected_masses[$];

   function automatic longint unsigned root64(input longint unsigned n);
      longint unsigned res = 0;
      longint unsigned b = 64'h1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic void rotate_phi(input logic signed [PHI_W-1:0] phi,
                                      output longint c, output longint s);
      bit [31:0] a;
      longint x, y, z, t;
      bit flip;
      a = {{(32-PHI_W){phi[PHI_W-1]}}, phi} << (32 - ANGLE_BITS_DEF);
      z = longint'(a);
      x = ROT_GAIN;
      y = 0;
      flip = 0;
      if (z >= 64'sd2147483648) z -= 64'sd4294967296;
      if (z > 64'sd1073741824) begin
         z -= 64'sd2147483648;
         flip = 1;
      end else if (z < -64'sd1073741824) begin
         z += 64'sd2147483648;
         flip = 1;
      end
      for (int i = 0; i < CORDIC_STAGES_DEF && i < 24; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z -= TURN_STEP[i];
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z += TURN_STEP[i];
         end
         x = t;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic momentum_type particle_vector(input logic mode,
         input logic [PT_W-1:0] pt_in, input logic signed [ETA_W-1:0] eta_in,
         input logic signed [PHI_W-1:0] phi_in, input logic [FOURTH_W-1:0] fourth);
      momentum_type v;
      longint pt, eta, c, s;
      longint unsigned mag, p, r, sh, pzm, m, sum;
      pt = longint'(pt_in);
      eta = longint'(eta_in);
      if (eta > 5120) eta = 5120;
      if (eta < -5120) eta = -5120;
      rotate_phi(phi_in, c, s);
      v.px = (pt * c + (64'sd1 << 25)) >>> 26;
      v.py = (pt * s + (64'sd1 << 25)) >>> 26;
      mag = (eta < 0) ? -eta : eta;
      p = 64'h1 << 24;
      for (int k = 0; k < 13; k++)
         if (mag[k]) p = (p * EXP_FACTOR[k] + (64'h1 << 23)) >> 24;
      r = ((64'h1 << 48) + (p >> 1)) / p;
      sh = (p >= r) ? (p - r) >> 1 : 0;
      pzm = (longint'(pt) * sh + (64'h1 << 19)) >> 20;
      v.pz = (eta < 0) ? -longint'(pzm) : longint'(pzm);
      m = longint'(fourth) << 4;
      if (mode == 1'b0) begin
         sum = v.px * v.px + v.py * v.py + v.pz * v.pz + m * m;
         v.e = root64(sum);
      end else begin
         v.e = m;
      end
      return v;
   endfunction

   function automatic mass_word_type pair_mass(input logic mode, input logic present,
         input logic [PT_W-1:0] pt1, input logic signed [ETA_W-1:0] eta1,
         input logic signed [PHI_W-1:0] phi1, input logic [FOURTH_W-1:0] f1,
         input logic [PT_W-1:0] pt2, input logic signed [ETA_W-1:0] eta2,
         input logic signed [PHI_W-1:0] phi2, input logic [FOURTH_W-1:0] f2);
      mass_word_type w;
      momentum_type a, b;
      longint ex, px, py, pz, m2, mass;
      longint unsigned r;
      w.pair_valid = 0;
      w.mass = '0;
      if (!present) return w;
      a = particle_vector(mode, pt1, eta1, phi1, f1);
      b = particle_vector(mode, pt2, eta2, phi2, f2);
      ex = a.e + b.e;
      px = a.px + b.px;
      py = a.py + b.py;
      pz = a.pz + b.pz;
      m2 = ex * ex - px * px - py * py - pz * pz;
      if (m2 >= 0) begin
         r = (root64(m2) + 8) >> 4;
         mass = (r > 8388607) ? 8388607 : longint'(r);
      end else begin
         r = (root64(-m2) + 8) >> 4;
         mass = (r > 8388608) ? -8388608 : -longint'(r);
      end
      w.pair_valid = 1;
      w.mass = mass[MASS_W-1:0];
      return w;
   endfunction

   assign pending = expected_masses.size();

   always @(posedge clock) begin
      mass_word_type want;
      if (reset) begin
         errors <= 0;
      end else begin
         if (start && !busy)
            expected_masses.push_back(pair_mass(req_mode, req_pair_present,
               req_first_pt, req_first_eta, req_first_phi, req_first_mass_or_energy,
               req_second_pt, req_second_eta, req_second_phi,
               req_second_mass_or_energy));
         if (rsp_valid) begin
            if (expected_masses.size() == 0) begin
               $display("%0t: unexpected word, pair_valid %0d mass %0d", $time,
                        rsp_pair_valid, rsp_invariant_mass);
               errors <= errors + 1;
            end else begin
               want = expected_masses.pop_front();
               if (rsp_pair_valid !== want.pair_valid) begin
                  $display("%0t: pair_valid expected %0d actual %0d", $time,
                           want.pair_valid, rsp_pair_valid);
                  errors <= errors + 1;
               end
               if (rsp_invariant_mass !== want.mass) begin
                  $display("%0t: invariant_mass expected %0d actual %0d", $time,
                           want.mass, rsp_invariant_mass);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

endmodule

@@ test/testbench.sv @@
// Top of the pair invariant mass testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
   import pim_pkg::*;

   localparam int IDLE_LIMIT = 4000;

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     start = 0;
   logic                     busy;
   logic                     req_mode = 0;
   logic                     req_pair_present = 0;
   logic [PT_W-1:0]          req_first_pt = '0;
   logic signed [ETA_W-1:0]  req_first_eta = '0;
   logic signed [PHI_W-1:0]  req_first_phi = '0;
   logic [FOURTH_W-1:0]      req_first_mass_or_energy = '0;
   logic [PT_W-1:0]          req_second_pt = '0;
   logic signed [ETA_W-1:0]  req_second_eta = '0;
   logic signed [PHI_W-1:0]  req_second_phi = '0;
   logic [FOURTH_W-1:0]      req_second_mass_or_energy = '0;
   logic                     rsp_valid;
   logic                     rsp_pair_valid;
   logic signed [MASS_W-1:0] rsp_invariant_mass;
   int                       errors;
   int                       pending;
   int                       idle_cycles = 0;

   pair_invariant_mass dut (.*);

   pim_checker u_checker (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic send_pair(input logic mode, input logic present,
         input logic [PT_W-1:0] pt1, input logic signed [ETA_W-1:0] eta1,
         input logic signed [PHI_W-1:0] phi1, input logic [FOURTH_W-1:0] f1,
         input logic [PT_W-1:0] pt2, input logic signed [ETA_W-1:0] eta2,
         input logic signed [PHI_W-1:0] phi2, input logic [FOURTH_W-1:0] f2);
      int gap;
      start <= 1;
      req_mode <= mode;
      req_pair_present <= present;
      req_first_pt <= pt1;
      req_first_eta <= eta1;
      req_first_phi <= phi1;
      req_first_mass_or_energy <= f1;
      req_second_pt <= pt2;
      req_second_eta <= eta2;
      req_second_phi <= phi2;
      req_second_mass_or_energy <= f2;
      do @(posedge clock); while (busy);
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4: gap = $urandom_range(1, 3);
         5:             gap = $urandom_range(10, 60);
         default:       gap = 0;
      endcase
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic signed [ETA_W-1:0] random_eta();
      if ($urandom_range(0, 9) == 0) return ETA_W'($urandom);
      return ETA_W'($urandom_range(0, 10240) - 5120);
   endfunction

   function automatic logic [PT_W-1:0] random_pt();
      if ($urandom_range(0, 3) == 0) return PT_W'($urandom_range(0, 400));
      return PT_W'($urandom);
   endfunction

   function automatic logic [FOURTH_W-1:0] random_fourth();
      if ($urandom_range(0, 2) == 0) return FOURTH_W'($urandom_range(0, 2000));
      return FOURTH_W'($urandom);
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_pair(0, 0, 100, 0, 0, 4, 200, 0, 1024, 4);
      send_pair(1, 0, 16'hFFFF, 5120, 2047, 23'h7FFFFF, 16'hFFFF, -5120, -2048, 0);
      send_pair(0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
      send_pair(1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
      send_pair(0, 1, 16'hFFFF, 0, 0, 0, 16'hFFFF, 0, -2048, 0);
      send_pair(0, 1, 16'hFFFF, 5120, 2047, 23'h7FFFFF, 16'hFFFF, -5120, -2048,
                23'h7FFFFF);
      send_pair(1, 1, 400, 0, 0, 23'h7FFFFF, 400, 0, 0, 23'h7FFFFF);
      send_pair(1, 1, 16'hFFFF, 5120, 0, 0, 16'hFFFF, 5120, 0, 0);
      send_pair(1, 1, 16'hFFFF, -5120, 1024, 0, 16'hFFFF, -5120, 1024, 0);
      send_pair(1, 1, 1000, 0, 0, 10, 1000, 0, 0, 10);
      send_pair(0, 1, 500, 8191, 1024, 2, 500, -8192, -1024, 2);
      send_pair(0, 1, 500, 5121, 512, 2, 500, -5121, -512, 2);
      send_pair(1, 1, 300, -8192, -2048, 5000, 300, 8191, 2047, 5000);
      send_pair(0, 1, 16'hFFFF, 2047, -1, 1, 1, -2048, 1, 16'h1234);
      send_pair(0, 1, 160, 1024, 2048 - 1, 2, 160, -1024, -1024, 2);
      send_pair(1, 1, 16'h8000, 4096, 1365, 23'h400000, 16'h7FFF, -4096, -1365,
                23'h3FFFFF);

      start <= 0;
      wait (pending == 0);

      for (int n = 0; n < 1640; n++) begin
         if (n == 800) begin
            start <= 0;
            wait (pending == 0);
         end
         send_pair(1'($urandom), $urandom_range(0, 15) != 0, random_pt(), random_eta(),
                   PHI_W'($urandom), random_fourth(), random_pt(), random_eta(),
                   PHI_W'($urandom), random_fourth());
      end
      start <= 0;

      wait (pending == 0);
      repeat (TOTAL_LAT + 20) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/pim_pkg.sv
design/pim_delay.sv
design/pim_isqrt.sv
design/pim_recip.sv
design/pim_cordic.sv
design/pim_lane.sv
design/pim_merge.sv
design/pair_invariant_mass.sv
design/pim_checker.sv
test/pim_checker.sv
test/testbench.sv
